>>> sv/kess_pkg.sv
`default_nettype none
package kess_pkg;
    localparam int MaxHeld = 32;
    localparam int KeyBits = 24;
    localparam int EntBits = 5;
    localparam int SlotBits = $clog2(MaxHeld);
    localparam int CntBits = $clog2(MaxHeld + 1);

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_ERASE = 3'd1;
    localparam logic [2:0] ACT_UPDATE = 3'd2;
    localparam logic [2:0] ACT_SORT = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_ERASE_READ,
        CMD_ERASE_MOVE,
        CMD_SET_KEY,
        CMD_CLEAR,
        CMD_SORT_LOAD,
        CMD_SORT_CMP,
        CMD_SORT_SWAP,
        CMD_REMAP,
        CMD_EMIT_READ
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic [SlotBits-1:0] idx;
    } ctrl_t;

    typedef struct packed {
        logic present;
        logic full;
        logic [CntBits-1:0] count;
        logic swap_needed;
    } stat_t;

    function automatic logic goes_before(input logic [KeyBits-1:0] ka,
                                         input logic [EntBits-1:0] ea,
                                         input logic [KeyBits-1:0] kb,
                                         input logic [EntBits-1:0] eb);
        logic lt;
        begin
            lt = $signed(ka) < $signed(kb);
            if (ka != kb)
            begin
                return lt;
            end
            return ea < eb;
        end
    endfunction
endpackage
`default_nettype wire

>>> sv/kess_datapath.sv
`default_nettype none
module kess_datapath
    import kess_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic load,
    input wire logic [EntBits-1:0] in_ent,
    input wire logic [KeyBits-1:0] in_key,
    input wire ctrl_t ctrl,
    output stat_t stat,
    output logic [EntBits-1:0] rd_ent,
    output logic [KeyBits-1:0] rd_key
);
    logic [KeyBits-1:0] keys_reg [MaxHeld];
    logic [EntBits-1:0] ids_reg [MaxHeld];
    logic [SlotBits-1:0] slot_reg [32];
    logic [31:0] present_reg;
    logic [CntBits-1:0] count_reg;
    logic [EntBits-1:0] ent_reg;
    logic [KeyBits-1:0] key_reg;
    logic [KeyBits-1:0] ka_reg;
    logic [KeyBits-1:0] kb_reg;
    logic [EntBits-1:0] ea_reg;
    logic [EntBits-1:0] eb_reg;
    logic [SlotBits-1:0] last_slot;
    logic [SlotBits-1:0] own_slot;

    assign last_slot = SlotBits'(count_reg - 1'b1);
    assign own_slot = slot_reg[ent_reg];
    assign stat.present = present_reg[ent_reg];
    assign stat.full = count_reg >= CntBits'(MaxHeld);
    assign stat.count = count_reg;
    assign stat.swap_needed = goes_before(kb_reg, eb_reg, ka_reg, ea_reg);
    assign rd_ent = ea_reg;
    assign rd_key = ka_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            unique case (ctrl.cmd)
                CMD_INSERT:
                begin
                    present_reg[ent_reg] <= 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
                CMD_ERASE_MOVE:
                begin
                    present_reg[ent_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                end
                CMD_CLEAR:
                begin
                    present_reg <= '0;
                    count_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= in_ent;
            key_reg <= in_key;
        end
        unique case (ctrl.cmd)
            CMD_INSERT:
            begin
                slot_reg[ent_reg] <= SlotBits'(count_reg);
                ids_reg[SlotBits'(count_reg)] <= ent_reg;
                keys_reg[SlotBits'(count_reg)] <= '0;
            end
            CMD_ERASE_READ:
            begin
                ea_reg <= ids_reg[last_slot];
                ka_reg <= keys_reg[last_slot];
            end
            CMD_ERASE_MOVE:
            begin
                keys_reg[own_slot] <= ka_reg;
                ids_reg[own_slot] <= ea_reg;
                slot_reg[ea_reg] <= own_slot;
            end
            CMD_SET_KEY:
            begin
                keys_reg[own_slot] <= key_reg;
            end
            CMD_SORT_LOAD, CMD_EMIT_READ:
            begin
                ka_reg <= keys_reg[ctrl.idx];
                ea_reg <= ids_reg[ctrl.idx];
                kb_reg <= keys_reg[SlotBits'(ctrl.idx + 1'b1)];
                eb_reg <= ids_reg[SlotBits'(ctrl.idx + 1'b1)];
            end
            CMD_SORT_SWAP:
            begin
                keys_reg[ctrl.idx] <= kb_reg;
                ids_reg[ctrl.idx] <= eb_reg;
                keys_reg[SlotBits'(ctrl.idx + 1'b1)] <= ka_reg;
                ids_reg[SlotBits'(ctrl.idx + 1'b1)] <= ea_reg;
            end
            CMD_REMAP:
            begin
                slot_reg[ids_reg[ctrl.idx]] <= ctrl.idx;
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

>>> sv/kess_ctrl.sv
`default_nettype none
module kess_ctrl
    import kess_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire logic [2:0] in_action,
    output logic load,
    output ctrl_t ctrl,
    input wire stat_t stat,
    input wire logic [EntBits-1:0] rd_ent,
    input wire logic [KeyBits-1:0] rd_key,
    output logic out_valid,
    input wire logic out_stall,
    output logic out_kind,
    output logic [EntBits-1:0] out_ent,
    output logic [KeyBits-1:0] out_key,
    output logic [CntBits-1:0] out_count,
    output logic out_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ERASE2, S_UPD2, S_PASS, S_CMP, S_NEXT,
        S_REMAP, S_EMIT_RD, S_EMIT, S_STATUS, S_WAIT
    } state_t;

    state_t state_reg;
    logic [2:0] act_reg;
    logic [SlotBits-1:0] idx_reg;
    logic swapped_reg;
    logic [CntBits-1:0] lim_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign load = in_valid && !in_stall;

    always_comb
    begin
        ctrl.cmd = CMD_NONE;
        ctrl.idx = idx_reg;
        unique case (state_reg)
            S_DECODE:
            begin
                priority if ((act_reg == ACT_INSERT || act_reg == ACT_UPDATE)
                             && !stat.present && !stat.full)
                begin
                    ctrl.cmd = CMD_INSERT;
                end
                else if (act_reg == ACT_ERASE && stat.present)
                begin
                    ctrl.cmd = CMD_ERASE_READ;
                end
                else if (act_reg == ACT_UPDATE && stat.present)
                begin
                    ctrl.cmd = CMD_SET_KEY;
                end
                else if (act_reg == ACT_CLEAR)
                begin
                    ctrl.cmd = CMD_CLEAR;
                end
                else
                begin
                    ctrl.cmd = CMD_NONE;
                end
            end
            S_ERASE2: ctrl.cmd = CMD_ERASE_MOVE;
            S_UPD2: ctrl.cmd = stat.present ? CMD_SET_KEY : CMD_NONE;
            S_PASS: ctrl.cmd = CMD_SORT_LOAD;
            S_CMP: ctrl.cmd = stat.swap_needed ? CMD_SORT_SWAP : CMD_NONE;
            S_REMAP: ctrl.cmd = CMD_REMAP;
            S_EMIT_RD: ctrl.cmd = CMD_EMIT_READ;
            default: ctrl.cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg <= ACT_INSERT;
            idx_reg <= '0;
            swapped_reg <= 1'b0;
            lim_reg <= '0;
            out_valid <= 1'b0;
            out_kind <= 1'b0;
            out_ent <= '0;
            out_key <= '0;
            out_count <= '0;
            out_last <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (load)
                    begin
                        act_reg <= in_action;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    idx_reg <= '0;
                    swapped_reg <= 1'b0;
                    lim_reg <= stat.count;
                    priority if (act_reg == ACT_ERASE && stat.present)
                    begin
                        state_reg <= S_ERASE2;
                    end
                    else if (act_reg == ACT_UPDATE && !stat.present && !stat.full)
                    begin
                        state_reg <= S_UPD2;
                    end
                    else if (act_reg == ACT_SORT && stat.count > CntBits'(1))
                    begin
                        state_reg <= S_PASS;
                    end
                    else if (act_reg == ACT_SORT && stat.count == CntBits'(1))
                    begin
                        state_reg <= S_REMAP;
                    end
                    else
                    begin
                        state_reg <= S_STATUS;
                    end
                end
                S_ERASE2, S_UPD2: state_reg <= S_STATUS;
                S_PASS: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (stat.swap_needed)
                    begin
                        swapped_reg <= 1'b1;
                    end
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (CntBits'(idx_reg) + 2'd2 < lim_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_PASS;
                    end
                    else if (swapped_reg)
                    begin
                        idx_reg <= '0;
                        swapped_reg <= 1'b0;
                        state_reg <= S_PASS;
                    end
                    else
                    begin
                        idx_reg <= '0;
                        state_reg <= S_REMAP;
                    end
                end
                S_REMAP:
                begin
                    if (CntBits'(idx_reg) + 1'b1 < lim_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        idx_reg <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    out_valid <= 1'b1;
                    out_kind <= 1'b1;
                    out_ent <= rd_ent;
                    out_key <= rd_key;
                    out_count <= lim_reg;
                    out_last <= (CntBits'(idx_reg) + 1'b1 == lim_reg);
                    state_reg <= S_WAIT;
                end
                S_STATUS:
                begin
                    out_valid <= 1'b1;
                    out_kind <= 1'b0;
                    out_ent <= '0;
                    out_key <= '0;
                    out_count <= stat.count;
                    out_last <= 1'b1;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        if (out_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/keyed_entity_set_sorter_unit.sv
// Channel   Handshake              Beat fields
// input     in_valid / in_stall    action, entity, key
// output    out_valid / out_stall  kind, out_entity, out_key, count, last
// Insert, clear and the other one-step actions pass through decode, status and output-wait
// states; erase adds a move state and an update that inserts adds a key-write state.
// Sort is a bubble sort that loads, compares and maybe swaps each adjacent pair in turn,
// with passes repeated until clean, then one entry per cycle to rebuild the slot map, then
// a read, emit and output wait per beat. Reset clears the presence marks and count at once.
// One item is worked at a time; the input stalls until its last beat is taken.
`default_nettype none
module keyed_entity_set_sorter_unit
    import kess_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire logic [2:0] action,
    input wire logic [EntBits-1:0] entity,
    input wire logic signed [KeyBits-1:0] key,
    output logic out_valid,
    input wire logic out_stall,
    output logic kind,
    output logic [EntBits-1:0] out_entity,
    output logic signed [KeyBits-1:0] out_key,
    output logic [CntBits-1:0] count,
    output logic last
);
    ctrl_t ctrl;
    stat_t stat;
    logic load;
    logic [EntBits-1:0] rd_ent;
    logic [KeyBits-1:0] rd_key;
    logic [KeyBits-1:0] key_u;

    assign out_key = $signed(key_u);

    kess_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_action(action), .load(load), .ctrl(ctrl), .stat(stat),
        .rd_ent(rd_ent), .rd_key(rd_key), .out_valid(out_valid),
        .out_stall(out_stall), .out_kind(kind), .out_ent(out_entity),
        .out_key(key_u), .out_count(count), .out_last(last)
    );

    kess_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .load(load), .in_ent(entity),
        .in_key(key), .ctrl(ctrl), .stat(stat), .rd_ent(rd_ent), .rd_key(rd_key)
    );
endmodule
`default_nettype wire

>>> sv/kess_checker.sv
`default_nettype none
module kess_checker
    import kess_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic kind,
    input wire logic [EntBits-1:0] out_entity,
    input wire logic [CntBits-1:0] count,
    input wire logic last
);
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= CntBits'(MaxHeld)) else $error("count too large");
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> last) else $error("status without last");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open during output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_entity))
        else $error("output beat dropped");
endmodule

bind keyed_entity_set_sorter_unit kess_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .out_entity(out_entity), .count(count), .last(last)
);
`default_nettype wire

>>> bench/keyed_entity_set_sorter_unit_check.sv
`default_nettype none
module keyed_entity_set_sorter_unit_check
    import kess_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic [2:0] action,
    input wire logic [EntBits-1:0] entity,
    input wire logic signed [KeyBits-1:0] key,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic kind,
    input wire logic [EntBits-1:0] out_entity,
    input wire logic signed [KeyBits-1:0] out_key,
    input wire logic [CntBits-1:0] count,
    input wire logic last,
    output int errors,
    output int pending
);
    typedef struct packed {
        logic kind;
        logic [EntBits-1:0] ent;
        logic signed [KeyBits-1:0] key;
        logic [CntBits-1:0] count;
        logic last;
    } beat_t;

    beat_t awaited[$];
    logic signed [KeyBits-1:0] keys[MaxHeld];
    logic [EntBits-1:0] ids[MaxHeld];
    logic [SlotBits-1:0] slot_of[32];
    logic held[32];
    int held_n;

    function automatic logic earlier(logic signed [KeyBits-1:0] ka, logic [EntBits-1:0] ea,
                                     logic signed [KeyBits-1:0] kb, logic [EntBits-1:0] eb);
        if (ka != kb)
        begin
            return ka < kb;
        end
        return ea < eb;
    endfunction

    task automatic add_entity(logic [EntBits-1:0] e);
        if (!held[e] && held_n < MaxHeld)
        begin
            slot_of[e] = held_n[SlotBits-1:0];
            ids[held_n] = e;
            keys[held_n] = '0;
            held[e] = 1'b1;
            held_n++;
        end
    endtask

    task automatic apply_action(logic [2:0] act, logic [EntBits-1:0] e,
                                logic signed [KeyBits-1:0] k);
        int i;
        int j;
        int fr;
        logic signed [KeyBits-1:0] tk;
        logic [EntBits-1:0] te;
        beat_t b;
        case (act)
            ACT_INSERT: add_entity(e);
            ACT_ERASE:
            begin
                if (held[e] && held_n > 0)
                begin
                    fr = slot_of[e];
                    keys[fr] = keys[held_n-1];
                    ids[fr] = ids[held_n-1];
                    slot_of[ids[fr]] = fr[SlotBits-1:0];
                    held[e] = 1'b0;
                    held_n--;
                end
            end
            ACT_UPDATE:
            begin
                add_entity(e);
                if (held[e])
                begin
                    keys[slot_of[e]] = k;
                end
            end
            ACT_SORT:
            begin
                for (i = 1; i < held_n; i++)
                begin
                    tk = keys[i];
                    te = ids[i];
                    j = i;
                    while (j > 0 && earlier(tk, te, keys[j-1], ids[j-1]))
                    begin
                        keys[j] = keys[j-1];
                        ids[j] = ids[j-1];
                        j--;
                    end
                    keys[j] = tk;
                    ids[j] = te;
                end
                for (i = 0; i < held_n; i++)
                begin
                    slot_of[ids[i]] = i[SlotBits-1:0];
                end
                if (held_n > 0)
                begin
                    for (i = 0; i < held_n; i++)
                    begin
                        b = '{1'b1, ids[i], keys[i], held_n[CntBits-1:0], i == held_n - 1};
                        awaited.push_back(b);
                    end
                    return;
                end
            end
            ACT_CLEAR:
            begin
                for (i = 0; i < 32; i++)
                begin
                    held[i] = 1'b0;
                end
                held_n = 0;
            end
            default: ;
        endcase
        b = '{1'b0, '0, '0, held_n[CntBits-1:0], 1'b1};
        awaited.push_back(b);
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        held_n = 0;
        for (int i = 0; i < 32; i++)
        begin
            held[i] = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        beat_t got;
        beat_t exp;
        if (rst_n && in_valid && !in_stall)
        begin
            apply_action(action, entity, key);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, out_entity, out_key, count, last};
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp = awaited.pop_front();
                if (got.kind !== exp.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
                    errors++;
                end
                if (got.ent !== exp.ent)
                begin
                    $display("%0t: out_entity expected %0d actual %0d", $time, exp.ent, got.ent);
                    errors++;
                end
                if (got.key !== exp.key)
                begin
                    $display("%0t: out_key expected %0d actual %0d", $time, exp.key, got.key);
                    errors++;
                end
                if (got.count !== exp.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, exp.count, got.count);
                    errors++;
                end
                if (got.last !== exp.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
                    errors++;
                end
            end
        end
        pending = awaited.size();
    end
endmodule
`default_nettype wire

>>> bench/keyed_entity_set_sorter_unit_test.sv
`default_nettype none
module keyed_entity_set_sorter_unit_test;
    import kess_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] action = ACT_INSERT;
    logic [EntBits-1:0] entity = '0;
    logic signed [KeyBits-1:0] key = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic kind;
    logic [EntBits-1:0] out_entity;
    logic signed [KeyBits-1:0] out_key;
    logic [CntBits-1:0] count;
    logic last;
    int errors;
    int pending;
    int cycles = 0;
    int sent = 0;
    bit calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    keyed_entity_set_sorter_unit DUT (.*);

    keyed_entity_set_sorter_unit_check checker_i (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("keyed_entity_set_sorter_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        int left;
        out_stall = 1'b0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (left > 0)
            begin
                left--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                left = $urandom_range(1, 16);
            end
            out_stall <= (left > 0);
        end
    end

    task automatic send(logic [2:0] a, logic [EntBits-1:0] e, logic signed [KeyBits-1:0] k);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        entity <= e;
        key <= k;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic random_item(int span);
        int r;
        logic [EntBits-1:0] e;
        e = EntBits'($urandom_range(0, span));
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            send(ACT_UPDATE, e, KeyBits'($urandom));
        end
        else if (r < 50)
        begin
            send(ACT_INSERT, e, KeyBits'($urandom));
        end
        else if (r < 70)
        begin
            send(ACT_ERASE, e, KeyBits'($urandom));
        end
        else if (r < 88)
        begin
            send(ACT_SORT, e, KeyBits'($urandom));
        end
        else if (r < 92)
        begin
            send(ACT_CLEAR, e, KeyBits'($urandom));
        end
        else if (r < 96)
        begin
            send(3'($urandom_range(5, 7)), e, KeyBits'($urandom));
        end
        else
        begin
            send(ACT_UPDATE, e, KeyBits'($urandom_range(0, 3) - 2));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(ACT_SORT, 5'd0, '0);
        send(ACT_ERASE, 5'd3, '0);
        send(ACT_INSERT, 5'd31, '0);
        send(ACT_INSERT, 5'd31, '0);
        send(ACT_UPDATE, 5'd0, 24'sh7FFFFF);
        send(ACT_UPDATE, 5'd7, 24'sh800000);
        send(ACT_UPDATE, 5'd9, 24'sh800000);
        send(ACT_UPDATE, 5'd31, -24'sd1);
        send(ACT_INSERT, 5'd12, 24'sh555555);
        send(ACT_SORT, 5'd0, '0);
        send(ACT_ERASE, 5'd7, '0);
        send(ACT_ERASE, 5'd7, '0);
        send(3'd5, 5'd1, '0);
        send(3'd7, 5'd30, '0);
        send(ACT_SORT, 5'd0, '0);
        send(ACT_CLEAR, 5'd0, '0);
        for (int i = 0; i < 32; i++)
        begin
            send(ACT_UPDATE, 5'(31 - i), KeyBits'($urandom_range(0, 3) - 1));
        end
        send(ACT_INSERT, 5'd31, '0);
        send(ACT_UPDATE, 5'd3, 24'sh123456);
        send(ACT_SORT, 5'd0, '0);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        send(ACT_CLEAR, 5'd0, '0);
        while (sent < 440)
        begin
            random_item(($urandom_range(0, 3) == 0) ? 31 : 7);
            if (sent > 400)
            begin
                calm = 1'b1;
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && cycles < 2000000)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("keyed_entity_set_sorter_unit: match");
        end
        else
        begin
            $display("keyed_entity_set_sorter_unit: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
